@@ rtl/cdq_pkg.sv @@
// cdq_pkg: shared constants and codes for the circular deque unit.
// Used by circular_deque_unit and cdq_ring_ram; depends on nothing.
`default_nettype none

package cdq_pkg;

   localparam int DepthDefault    = 128;
   localparam int WordBitsDefault = 32;

   localparam int ModeBits      = 3;
   localparam int ValueBits     = 32;
   localparam int StatusBits    = 2;
   localparam int OccupancyBits = 8;

   typedef enum logic [ModeBits-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_PEEK       = 3'd4
   } mode_type;

   typedef enum logic [StatusBits-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

endpackage

`default_nettype wire

@@ rtl/circular_deque_unit.sv @@
// circular_deque_unit: double-ended queue over a ring store, top level.
// Depends on cdq_pkg and cdq_ring_ram.
//
//   channel   ports                          handshake
//   --------  -----------------------------  -------------------------------
//   request   req_mode, req_value            accepted when start && !busy
//   response  rsp_status, rsp_front_value,   one cycle, marked by rsp_valid
//             rsp_back_value, rsp_is_empty,
//             rsp_is_full, rsp_occupancy
//
// One item per cycle: indices and count update at the accept edge, the push
// word is written and both end words are read in that same edge through the
// RAM's two read ports, with write-to-read forwarding. The response appears
// in the cycle after accept. Reset is synchronous and clears indices and
// count; busy is high for the cycle after reset. The receiver cannot stall.
`default_nettype none

module circular_deque_unit #(
   parameter int DEPTH     = cdq_pkg::DepthDefault,
   parameter int WORD_BITS = cdq_pkg::WordBitsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [cdq_pkg::ModeBits-1:0]        req_mode,
   input  wire logic signed [cdq_pkg::ValueBits-1:0] req_value,
   output logic                                     rsp_valid,
   output logic      [cdq_pkg::StatusBits-1:0]      rsp_status,
   output logic signed [cdq_pkg::ValueBits-1:0]     rsp_front_value,
   output logic signed [cdq_pkg::ValueBits-1:0]     rsp_back_value,
   output logic                                     rsp_is_empty,
   output logic                                     rsp_is_full,
   output logic      [cdq_pkg::OccupancyBits-1:0]   rsp_occupancy
);

   localparam int IdxBits   = $clog2(DEPTH);
   localparam int CountBits = $clog2(DEPTH + 1);
   localparam int OutBits   = (WORD_BITS < cdq_pkg::ValueBits) ? WORD_BITS
                                                               : cdq_pkg::ValueBits;
   localparam logic [IdxBits-1:0]   LastIdx   = IdxBits'(DEPTH - 1);
   localparam logic [CountBits-1:0] FullCount = CountBits'(DEPTH);

   logic [IdxBits-1:0]   head_ff, head_in;
   logic [IdxBits-1:0]   tail_ff, tail_in;
   logic [CountBits-1:0] count_ff, count_in;
   cdq_pkg::status_type  status_ff, status_in;
   logic                 valid_ff;
   logic                 busy_ff;

   logic                 accept;
   logic                 wr_en;
   logic [IdxBits-1:0]   wr_addr;
   logic [IdxBits-1:0]   back_addr;
   logic [IdxBits-1:0]   head_inc, head_dec, tail_inc, tail_dec;
   logic                 is_full_now, is_empty_now;
   logic [WORD_BITS-1:0] wr_word;
   logic [WORD_BITS-1:0] front_word, back_word;

   assign accept       = start && !busy_ff;
   assign is_full_now  = (count_ff == FullCount);
   assign is_empty_now = (count_ff == '0);

   assign head_inc = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LastIdx : head_ff - 1'b1;
   assign tail_inc = (tail_ff == LastIdx) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LastIdx : tail_ff - 1'b1;

   assign wr_word = WORD_BITS'($unsigned(req_value));

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = cdq_pkg::STATUS_DONE;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      if (accept) begin
         case (req_mode)
            cdq_pkg::MODE_PUSH_FRONT: begin
               if (is_full_now) begin
                  status_in = cdq_pkg::STATUS_OVERFLOW;
               end else begin
                  head_in  = head_dec;
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            cdq_pkg::MODE_PUSH_BACK: begin
               if (is_full_now) begin
                  status_in = cdq_pkg::STATUS_OVERFLOW;
               end else begin
                  tail_in  = tail_inc;
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  count_in = count_ff + 1'b1;
               end
            end
            cdq_pkg::MODE_POP_FRONT: begin
               if (is_empty_now) begin
                  status_in = cdq_pkg::STATUS_UNDERFLOW;
               end else begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            cdq_pkg::MODE_POP_BACK: begin
               if (is_empty_now) begin
                  status_in = cdq_pkg::STATUS_UNDERFLOW;
               end else begin
                  tail_in  = tail_dec;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               // peek and unused codes: leave state alone
            end
         endcase
      end
   end

   // back word sits one slot before the new tail
   assign back_addr = (tail_in == '0) ? LastIdx : tail_in - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         status_ff <= cdq_pkg::STATUS_DONE;
         valid_ff  <= 1'b0;
         busy_ff   <= 1'b1;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         valid_ff  <= accept;
         busy_ff   <= 1'b0;
      end
   end

   cdq_ring_ram #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ring (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_word),
      .rd_a_addr (head_in),
      .rd_b_addr (back_addr),
      .rd_a_data (front_word),
      .rd_b_data (back_word)
   );

   assign busy            = busy_ff;
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_is_empty    = is_empty_now;
   assign rsp_is_full     = is_full_now;
   assign rsp_occupancy   = cdq_pkg::OccupancyBits'(count_ff);
   assign rsp_front_value = is_empty_now ? '1
                          : cdq_pkg::ValueBits'(front_word[OutBits-1:0]);
   assign rsp_back_value  = is_empty_now ? '1
                          : cdq_pkg::ValueBits'(back_word[OutBits-1:0]);

endmodule

`default_nettype wire

@@ rtl/cdq_ring_ram.sv @@
// cdq_ring_ram: ring store with one write port and two registered read ports.
// A read at the address being written returns the new word. Uses cdq_pkg defaults.
`default_nettype none

module cdq_ring_ram #(
   parameter int DEPTH     = cdq_pkg::DepthDefault,
   parameter int WORD_BITS = cdq_pkg::WordBitsDefault,
   localparam int IdxBits  = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [IdxBits-1:0]   wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data,
   input  wire logic [IdxBits-1:0]   rd_a_addr,
   input  wire logic [IdxBits-1:0]   rd_b_addr,
   output logic      [WORD_BITS-1:0] rd_a_data,
   output logic      [WORD_BITS-1:0] rd_b_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_a_ff;
   logic [WORD_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward the word written in the same cycle
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_a_addr)) begin
         rd_a_ff <= wr_data;
      end else begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (wr_en && (wr_addr == rd_b_addr)) begin
         rd_b_ff <= wr_data;
      end else begin
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire
